// ----- hdl/acdm_pkg.sv -----
package acdm_pkg;

    localparam int SPEAKERS_DEF  = 32;
    localparam int MAX_ORDER_DEF = 3;

    localparam int CH_W       = 4;
    localparam int ORD_W      = 2;
    localparam int COEF_W     = 16;
    localparam int SAMP_W     = 24;
    localparam int PROD_W     = COEF_W + SAMP_W;
    localparam int ACC_W      = PROD_W + CH_W;
    localparam int FRAC_SHIFT = 14;
    localparam int CHANS      = 16;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_PUBLISH = 2'd1,
        CMD_SAMPLE  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    localparam logic REG_SPEAKER_COUNT = 1'b0;
    localparam logic REG_DECODE_ORDER  = 1'b1;

    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctl_t;

    // index of the last ACN channel for orders 1..3
    function automatic logic [CH_W-1:0] chan_last(input logic [ORD_W-1:0] ord);
        logic [CH_W-1:0] r;
        case (ord)
            2'd2:    r = 4'd8;
            2'd3:    r = 4'd15;
            default: r = 4'd3;
        endcase
        return r;
    endfunction

    // Q7.37 sum -> Q1.23, round half up, saturate
    function automatic logic [SAMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]            sum;
        logic        [ACC_W-FRAC_SHIFT:0] q;
        logic        [SAMP_W-1:0]         r;
        sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_SHIFT - 1));
        q   = sum[ACC_W:FRAC_SHIFT];
        if (&q[ACC_W-FRAC_SHIFT:SAMP_W-1] || !(|q[ACC_W-FRAC_SHIFT:SAMP_W-1]))
            r = q[SAMP_W-1:0];
        else if (q[ACC_W-FRAC_SHIFT])
            r = {1'b1, {(SAMP_W-1){1'b0}}};
        else
            r = {1'b0, {(SAMP_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// ----- hdl/acdm_coef_ram.sv -----
module acdm_coef_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/acdm_mac.sv -----
module acdm_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  acdm_pkg::mac_ctl_t                  ctl,
    input  logic signed [acdm_pkg::COEF_W-1:0]  coef,
    input  logic signed [acdm_pkg::SAMP_W-1:0]  samp,
    output logic signed [acdm_pkg::ACC_W-1:0]   acc,
    output logic                                busy
);

    logic                                v2_reg;
    logic                                first2_reg;
    logic signed [acdm_pkg::PROD_W-1:0]  prod_reg;
    logic signed [acdm_pkg::PROD_W-1:0]  prod_next;
    logic signed [acdm_pkg::ACC_W-1:0]   acc_reg;
    logic signed [acdm_pkg::ACC_W-1:0]   acc_next;

    assign prod_next = coef * samp;

    always_comb
    begin
        if (first2_reg)
            acc_next = acdm_pkg::ACC_W'(prod_reg);
        else
            acc_next = acc_reg + acdm_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg     <= 1'b0;
            first2_reg <= 1'b0;
        end
        else
        begin
            v2_reg     <= ctl.valid;
            first2_reg <= ctl.first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= prod_next;
        end
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign busy = ctl.valid | v2_reg;

endmodule

// ----- hdl/ambisonic_decode_matrix_mixer_core.sv -----
// A frame-completing sample beat (K = 4, 9, 16 channels of the decode order) starts one
// speaker feed after another; each feed makes one coefficient-RAM read and one shared
// multiply-accumulate per cycle over its K channels, then waits until the feed is taken.
// Other beats are accepted one per cycle while idle; input is not ready while feeds run.
// Reset (rst_n low, async) clears control, frame buffer, bank select and config;
// coefficient RAM is not cleared.
module ambisonic_decode_matrix_mixer_core #(
    parameter int SPEAKERS       = acdm_pkg::SPEAKERS_DEF,
    parameter int MAX_AMBI_ORDER = acdm_pkg::MAX_ORDER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // matrix_order, speaker, channel, coefficient, sample, zero pad
    input  logic [55:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_speaker, feed, zero pad
    output logic [31:0] m_axis_tdata,
    // block_end
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int SPK_W  = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
    localparam int CNT_W  = $clog2(SPEAKERS + 1);
    localparam int ADDR_W = 1 + acdm_pkg::ORD_W + SPK_W + acdm_pkg::CH_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                             state_reg;
    logic [5:0]                         speaker_count_reg;
    logic [2:0]                         decode_order_reg;
    logic                               bank_reg;
    logic [acdm_pkg::SAMP_W-1:0]        frame_reg [acdm_pkg::CHANS];
    logic [acdm_pkg::CH_W-1:0]          kk_reg;
    logic [acdm_pkg::CH_W-1:0]          k_last_reg;
    logic [acdm_pkg::ORD_W-1:0]         ord_reg;
    logic [SPK_W-1:0]                   spk_reg;
    logic [CNT_W-1:0]                   n_reg;
    logic                               eob_reg;
    logic [acdm_pkg::SAMP_W-1:0]        samp_reg;
    acdm_pkg::mac_ctl_t                 mac_ctl_reg;
    logic [acdm_pkg::SAMP_W-1:0]        out_feed_reg;
    logic [4:0]                         out_spk_reg;
    logic                               out_last_reg;
    logic                               out_valid_reg;

    acdm_pkg::cmd_t                     in_cmd;
    logic [acdm_pkg::ORD_W-1:0]         in_mord;
    logic [4:0]                         in_spk;
    logic [acdm_pkg::CH_W-1:0]          in_ch;
    logic [acdm_pkg::COEF_W-1:0]        in_coef;
    logic [acdm_pkg::SAMP_W-1:0]        in_samp;

    logic                               accept_in;
    logic [acdm_pkg::ORD_W-1:0]         ord_eff;
    logic [acdm_pkg::CH_W-1:0]          k_last_eff;
    logic [CNT_W-1:0]                   n_eff;
    logic                               start;
    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_waddr;
    logic [ADDR_W-1:0]                  ram_raddr;
    logic [acdm_pkg::COEF_W-1:0]        ram_rdata;
    logic signed [acdm_pkg::ACC_W-1:0]  mac_acc;
    logic                               mac_busy;
    logic [SPK_W:0]                     spk_inc;
    logic                               spk_is_last;

    assign in_cmd  = acdm_pkg::cmd_t'(s_axis_tuser);
    assign in_mord = s_axis_tdata[1:0];
    assign in_spk  = s_axis_tdata[6:2];
    assign in_ch   = s_axis_tdata[10:7];
    assign in_coef = s_axis_tdata[26:11];
    assign in_samp = s_axis_tdata[50:27];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept_in     = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (decode_order_reg >= 3'd1 && 32'(decode_order_reg) <= MAX_AMBI_ORDER)
            ord_eff = decode_order_reg[1:0];
        else
            ord_eff = 2'd1;
        k_last_eff = acdm_pkg::chan_last(ord_eff);
        if (32'(speaker_count_reg) > SPEAKERS)
            n_eff = CNT_W'(SPEAKERS);
        else
            n_eff = CNT_W'(speaker_count_reg);
    end

    assign start = accept_in && (in_cmd == acdm_pkg::CMD_SAMPLE) && (in_ch == k_last_eff)
                   && (n_eff != '0);

    assign ram_we = accept_in && (in_cmd == acdm_pkg::CMD_WRITE) && (in_mord != 2'd0)
                    && (32'(in_mord) <= MAX_AMBI_ORDER) && (32'(in_spk) < SPEAKERS);
    assign ram_waddr = {~bank_reg, in_mord - 2'd1, SPK_W'(in_spk), in_ch};
    assign ram_raddr = {bank_reg, ord_reg - 2'd1, spk_reg, kk_reg};

    assign spk_inc     = (SPK_W+1)'(spk_reg) + (SPK_W+1)'(1);
    assign spk_is_last = (spk_inc == (SPK_W+1)'(n_reg));

    acdm_coef_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (acdm_pkg::COEF_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_coef),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    acdm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl_reg),
        .coef  (ram_rdata),
        .samp  (samp_reg),
        .acc   (mac_acc),
        .busy  (mac_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speaker_count_reg <= 6'd8;
            decode_order_reg  <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                acdm_pkg::REG_SPEAKER_COUNT: speaker_count_reg <= cfg_data;
                acdm_pkg::REG_DECODE_ORDER:  decode_order_reg  <= cfg_data[2:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < acdm_pkg::CHANS; i++)
            begin
                frame_reg[i] <= '0;
            end
        end
        else if (accept_in && in_cmd == acdm_pkg::CMD_SAMPLE)
        begin
            frame_reg[in_ch] <= in_samp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            kk_reg        <= '0;
            k_last_reg    <= '0;
            ord_reg       <= 2'd1;
            spk_reg       <= '0;
            n_reg         <= '0;
            eob_reg       <= 1'b0;
            samp_reg      <= '0;
            mac_ctl_reg   <= '0;
            out_feed_reg  <= '0;
            out_spk_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    mac_ctl_reg <= '0;
                    if (accept_in && in_cmd == acdm_pkg::CMD_PUBLISH)
                    begin
                        bank_reg <= ~bank_reg;
                    end
                    if (start)
                    begin
                        ord_reg    <= ord_eff;
                        k_last_reg <= k_last_eff;
                        n_reg      <= n_eff;
                        eob_reg    <= s_axis_tlast;
                        spk_reg    <= '0;
                        kk_reg     <= '0;
                        state_reg  <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    mac_ctl_reg <= '{valid: 1'b1, first: (kk_reg == '0)};
                    samp_reg    <= frame_reg[kk_reg];
                    if (kk_reg == k_last_reg)
                        state_reg <= ST_DRAIN;
                    else
                        kk_reg <= kk_reg + 4'd1;
                end
                ST_DRAIN:
                begin
                    mac_ctl_reg <= '0;
                    if (!mac_busy)
                    begin
                        out_feed_reg  <= acdm_pkg::round_sat(mac_acc);
                        out_spk_reg   <= 5'(spk_reg);
                        out_last_reg  <= spk_is_last;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    mac_ctl_reg <= '0;
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            spk_reg   <= spk_inc[SPK_W-1:0];
                            kk_reg    <= '0;
                            state_reg <= ST_MAC;
                        end
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_feed_reg, out_spk_reg};
    assign m_axis_tuser  = eob_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a feed beat is pending");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("not ready after final feed of a frame");

    a_more_speakers: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready && !m_axis_tvalid)
        else $error("frame ended before last speaker");

    a_mac_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mac_busy)
        else $error("accumulator active while idle");
`endif

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSPK        = 32;
    localparam int NORD        = 3;
    localparam int DRAIN_CYC   = 700;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        acdm_pkg::cmd_t cmd;
        logic [1:0]     mord;
        logic [4:0]     spk;
        logic [3:0]     ch;
        logic [15:0]    coef;
        logic [23:0]    smp;
        logic           eob;
    } beat_t;

    typedef struct {
        logic [4:0]  spk;
        logic [23:0] feed;
        logic        last;
        logic        blk_end;
    } feed_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // matrix_order, speaker, channel, coefficient, sample, zero pad
    logic [55:0] s_axis_tdata  = '0;
    // command
    logic [1:0]  s_axis_tuser  = acdm_pkg::CMD_NOP;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_speaker, feed, zero pad
    logic [31:0] m_axis_tdata;
    // block_end
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = acdm_pkg::REG_SPEAKER_COUNT;
    logic [5:0]  cfg_data      = '0;

    beat_t beats_pending[$];
    feed_t feeds_due[$];
    beat_t cur_beat;
    int    beats_pushed = 0;
    int    beats_taken  = 0;
    int    fails        = 0;
    int    cycles       = 0;
    bit    calm         = 1'b0;

    // mixer state as seen from outside
    logic [15:0] coef_mem [0:2*NORD*NSPK*16-1];
    logic        bank_sel;
    logic [23:0] frame_mem [0:15];
    logic [5:0]  spk_cnt;
    logic [2:0]  dec_ord;

    ambisonic_decode_matrix_mixer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int chans_of(input logic [2:0] ord);
        return (ord == 3'd2) ? 9 : (ord == 3'd3) ? 16 : 4;
    endfunction

    function automatic int coef_addr(input logic bank, input int ord, input int spk,
                                     input int ch);
        return ((int'(bank) * NORD + ord - 1) * NSPK + spk) * 16 + ch;
    endfunction

    function automatic void predict_feeds(input beat_t b);
        int     ord;
        int     k;
        int     n;
        longint acc;
        longint r;
        feed_t  f;
        case (b.cmd)
            acdm_pkg::CMD_WRITE:
                if (b.mord != 2'd0)
                    coef_mem[coef_addr(~bank_sel, b.mord, b.spk, b.ch)] = b.coef;
            acdm_pkg::CMD_PUBLISH:
                bank_sel = ~bank_sel;
            acdm_pkg::CMD_SAMPLE:
            begin
                frame_mem[b.ch] = b.smp;
                ord = (dec_ord == 3'd2 || dec_ord == 3'd3) ? int'(dec_ord) : 1;
                k   = chans_of(3'(ord));
                if (int'(b.ch) == k - 1)
                begin
                    n = (spk_cnt > NSPK) ? NSPK : int'(spk_cnt);
                    for (int s = 0; s < n; s++)
                    begin
                        acc = 0;
                        for (int c = 0; c < k; c++)
                            acc += longint'($signed(coef_mem[coef_addr(bank_sel, ord, s, c)]))
                                 * longint'($signed(frame_mem[c]));
                        r = (acc + 64'sd8192) >>> 14;
                        if (r > 8388607)
                            r = 8388607;
                        else if (r < -8388608)
                            r = -8388608;
                        f.spk     = 5'(s);
                        f.feed    = r[23:0];
                        f.last    = (s == n - 1);
                        f.blk_end = b.eob;
                        feeds_due.push_back(f);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void push_beat(input acdm_pkg::cmd_t cmd, input logic [1:0] mord,
                                      input logic [4:0] spk, input logic [3:0] ch,
                                      input logic [15:0] coef, input logic [23:0] smp,
                                      input logic eob);
        beat_t b;
        b.cmd  = cmd;
        b.mord = mord;
        b.spk  = spk;
        b.ch   = ch;
        b.coef = coef;
        b.smp  = smp;
        b.eob  = eob;
        beats_pending.push_back(b);
        beats_pushed++;
    endfunction

    function automatic void push_write(input logic [1:0] mord, input logic [4:0] spk,
                                       input logic [3:0] ch, input logic [15:0] coef);
        push_beat(acdm_pkg::CMD_WRITE, mord, spk, ch, coef, 24'($urandom), 1'($urandom));
    endfunction

    function automatic void push_sample(input logic [3:0] ch, input logic [23:0] smp,
                                        input logic eob);
        push_beat(acdm_pkg::CMD_SAMPLE, 2'($urandom), 5'($urandom), ch, 16'($urandom),
                  smp, eob);
    endfunction

    function automatic void push_other(input acdm_pkg::cmd_t cmd);
        push_beat(cmd, 2'($urandom), 5'($urandom), 4'($urandom), 16'($urandom),
                  24'($urandom), 1'($urandom));
    endfunction

    function automatic logic [23:0] rnd_smp();
        case ($urandom_range(9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3, 4: return 24'($urandom);
            default: return 24'($urandom_range(2097151)) - 24'd1048576;
        endcase
    endfunction

    function automatic logic [15:0] rnd_coef();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom);
            default: return 16'($urandom_range(8191)) - 16'd4096;
        endcase
    endfunction

    function automatic void push_frame(input int k, input logic eob);
        for (int c = 0; c < k; c++)
            push_sample(4'(c), rnd_smp(), eob);
    endfunction

    // fill the rows a frame will read; each pass writes the idle bank, then swaps
    function automatic void load_rows(input int rows, input int ord, input int banks);
        for (int p = 0; p < banks; p++)
        begin
            for (int s = 0; s < rows; s++)
                for (int c = 0; c < chans_of(3'(ord)); c++)
                    push_write(2'(ord), 5'(s), 4'(c), rnd_coef());
            push_other(acdm_pkg::CMD_PUBLISH);
        end
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    task automatic settle();
        while (beats_taken != beats_pushed || feeds_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [5:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == acdm_pkg::REG_SPEAKER_COUNT)
            spk_cnt = val;
        else
            dec_ord = val[2:0];
    endtask

    task automatic run_phase(input logic [5:0] spk, input logic [2:0] ord, input int n,
                             input bit quiet, input bit swaps);
        int done;
        int k;
        int r;
        int m;
        int rows;
        int ord_eff;
        settle();
        set_reg(acdm_pkg::REG_SPEAKER_COUNT, spk);
        set_reg(acdm_pkg::REG_DECODE_ORDER, {3'($urandom), ord});
        calm    = quiet;
        k       = chans_of(ord);
        rows    = (spk > NSPK) ? NSPK : int'(spk);
        ord_eff = (ord == 3'd2 || ord == 3'd3) ? int'(ord) : 1;
        if (rows != 0)
            load_rows(rows, ord_eff, swaps ? 2 : 1);
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                push_frame(k, 1'($urandom));
                done += k;
            end
            else if (r < 70)
            begin
                // broken frame: stray channels, then the closing one
                m = $urandom_range(k - 1);
                for (int i = 0; i < m; i++)
                    push_sample(4'($urandom_range(15)), rnd_smp(), 1'($urandom));
                push_sample(4'(k - 1), rnd_smp(), 1'($urandom));
                done += m + 1;
            end
            else if (r < 80)
            begin
                push_write(2'($urandom), 5'($urandom), 4'($urandom), rnd_coef());
                done++;
            end
            else if (r < 85)
            begin
                if (swaps)
                    push_other(acdm_pkg::CMD_PUBLISH);
                else
                    push_other(acdm_pkg::CMD_NOP);
                done++;
            end
            else if (r < 93)
            begin
                push_sample(4'($urandom), rnd_smp(), 1'($urandom));
                done++;
            end
            else
                push_other(acdm_pkg::CMD_NOP);
        end
    endtask

    // stimulus driver
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_feeds(cur_beat);
            beats_taken++;
        end
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (rst_n && beats_pending.size() != 0 && (calm || $urandom_range(99) >= 38))
            begin
                cur_beat = beats_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'd0, cur_beat.smp, cur_beat.coef, cur_beat.ch,
                                  cur_beat.spk, cur_beat.mord};
                s_axis_tuser  <= cur_beat.cmd;
                s_axis_tlast  <= cur_beat.eob;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // feed beat monitor
    always @(posedge clk)
    begin
        feed_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (feeds_due.size() == 0)
            begin
                $error("unexpected feed beat: out_speaker %0d, feed %0d",
                       m_axis_tdata[4:0], $signed(m_axis_tdata[28:5]));
                fails++;
            end
            else
            begin
                want = feeds_due.pop_front();
                check_field("out_speaker", want.spk, m_axis_tdata[4:0]);
                check_field("feed", $signed(want.feed), $signed(m_axis_tdata[28:5]));
                check_field("last", want.last, m_axis_tlast);
                check_field("block_end", want.blk_end, m_axis_tuser);
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 38);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[ambisonic_decode_matrix_mixer_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        bank_sel = 1'b0;
        spk_cnt  = 6'd8;
        dec_ord  = 3'd1;
        for (int c = 0; c < 16; c++)
            frame_mem[c] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // rows read under the reset setting (8 speakers, order 1), both banks
        load_rows(8, 1, 2);

        // directed: saturation both ways under the reset setting
        for (int c = 0; c < 4; c++)
        begin
            push_write(2'd1, 5'd0, 4'(c), 16'h7FFF);
            push_write(2'd1, 5'd1, 4'(c), 16'h8000);
        end
        push_other(acdm_pkg::CMD_PUBLISH);
        for (int c = 0; c < 4; c++)
            push_sample(4'(c), 24'h7FFFFF, 1'b1);
        for (int c = 0; c < 4; c++)
            push_sample(4'(c), 24'h800000, 1'b0);
        // write with order 0 is dropped
        push_write(2'd0, 5'd31, 4'd15, 16'h5A5A);
        push_other(acdm_pkg::CMD_NOP);
        // channel above the order only lands in the frame buffer
        push_sample(4'd9, 24'h123456, 1'b1);
        // lone closing channel reuses stale frame contents
        push_sample(4'd3, 24'h000001, 1'b1);

        // count above the speaker limit, order out of range; no idling, no swaps
        run_phase(6'd63, 3'd6, 20, 1'b1, 1'b0);
        run_phase(6'd1,  3'd2, 30, 1'b0, 1'b1);
        run_phase(6'd0,  3'd0, 20, 1'b0, 1'b1);
        run_phase(6'd2,  3'd3, 40, 1'b0, 1'b1);
        settle();

        if (fails == 0)
            $display("[ambisonic_decode_matrix_mixer_core] OK");
        else
            $display("[ambisonic_decode_matrix_mixer_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/acdm_pkg.sv
hdl/acdm_coef_ram.sv
hdl/acdm_mac.sv
hdl/ambisonic_decode_matrix_mixer_core.sv
dv/tb_top.sv
